// ===== rtl/rrtt_pkg.sv =====
// Shared types and codes for the round-robin task table.
package rrtt_pkg;

  localparam int unsigned HandleW  = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned OutDataW = 48;

  localparam logic [KindW-1:0] KIND_ADD   = 2'd0;
  localparam logic [KindW-1:0] KIND_SCHED = 2'd1;
  localparam logic [KindW-1:0] KIND_EXIT  = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic load;
    logic shift;
    logic mark;
    logic sel;
  } rrtt_cell_ctrl_t;

endpackage

// ===== rtl/round_robin_task_table.sv =====
// Round-robin task table: control and a compacting row of table cells.
//
// Input stream: s_axis_tuser carries the transaction kind (add, schedule
// tick, exit), s_axis_tdata the handle to append. Output stream: one result
// per input transaction, status in m_axis_tuser and the chosen handle,
// chosen index, live count and removed count in m_axis_tdata.
// Flow: add, exit and unknown kinds, and a schedule tick on an empty table,
// go from acceptance straight to the final step, where the result is loaded
// into the output register; any other schedule tick first passes through the
// scan step, which deletes one finished entry per shift-down step of the cell
// row and moves on to the final step once the current entry is unfinished or
// the deletions empty the table. An item occupies the controller from
// acceptance until its result is loaded into the output register, so no new
// item is accepted before then.
// The output register holds a result while the receiver stalls; the next
// item is accepted and processed meanwhile and waits at its final step.
// Reset clears the count, the current position and all finished marks;
// handle storage is not cleared and only written slots are ever read.
module round_robin_task_table import rrtt_pkg::*; #(
  parameter int unsigned MAX_TASKS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [HandleW-1:0]   s_axis_tdata,  // [15:0] new_handle
  input  logic [KindW-1:0]     s_axis_tuser,  // [1:0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] chosen_handle, [23:16] chosen_index, [32:24] live_count,
  // [41:33] removed_count, [47:42] zero
  output logic [OutDataW-1:0]  m_axis_tdata,
  output logic [StatusW-1:0]   m_axis_tuser   // [1:0] status
);

  localparam int unsigned PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic                valid_q, valid_d;
  logic [CW-1:0]       removed_q, removed_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic                show_q, show_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [StatusW-1:0]  out_status_q;

  logic load_en, shift_en, mark_en;
  logic s_acc, out_load;
  logic [CW-1:0] pos_nxt, cnt_m1;

  logic [HandleW-1:0] cell_handle [MAX_TASKS];
  logic               cell_fin    [MAX_TASKS];
  logic [HandleW-1:0] cell_rd_h   [MAX_TASKS];
  logic               cell_rd_f   [MAX_TASKS];
  logic [HandleW-1:0] rd_handle;
  logic               rd_fin;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    rrtt_cell_ctrl_t    ctrl;
    logic [HandleW-1:0] nxt_h;
    logic               nxt_f;

    assign ctrl.load  = load_en && (CW'(i) == count_q);
    assign ctrl.shift = shift_en && (CW'(i) >= CW'(pos_q));
    assign ctrl.sel   = (PW'(i) == pos_q);
    assign ctrl.mark  = mark_en && ctrl.sel;

    if (i < MAX_TASKS - 1) begin : g_mid
      assign nxt_h = cell_handle[i+1];
      assign nxt_f = cell_fin[i+1];
    end else begin : g_end
      assign nxt_h = '0;
      assign nxt_f = 1'b0;
    end

    rrtt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_handle_i (s_axis_tdata),
      .nxt_handle_i (nxt_h),
      .nxt_fin_i    (nxt_f),
      .handle_o     (cell_handle[i]),
      .fin_o        (cell_fin[i]),
      .rd_handle_o  (cell_rd_h[i]),
      .rd_fin_o     (cell_rd_f[i])
    );
  end

  always_comb begin
    rd_handle = '0;
    rd_fin    = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      rd_handle = rd_handle | cell_rd_h[i];
      rd_fin    = rd_fin | cell_rd_f[i];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign cnt_m1        = count_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    valid_d   = valid_q;
    removed_d = removed_q;
    status_d  = status_q;
    show_d    = show_q;
    load_en   = 1'b0;
    shift_en  = 1'b0;
    mark_en   = 1'b0;
    pos_nxt   = CW'(pos_q) + CW'(1);
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          removed_d = '0;
          show_d    = 1'b0;
          state_d   = ST_FIN;
          unique case (s_axis_tuser)
            KIND_ADD: begin
              if (count_q >= CW'(MAX_TASKS)) begin
                status_d = STATUS_FULL;
              end else begin
                status_d = STATUS_OK;
                load_en  = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            KIND_SCHED: begin
              if (count_q == '0) begin
                status_d = STATUS_NONE;
              end else begin
                if (!valid_q || pos_nxt >= count_q) begin
                  pos_nxt = '0;
                end
                pos_d   = pos_nxt[PW-1:0];
                valid_d = 1'b1;
                state_d = ST_SCAN;
              end
            end
            KIND_EXIT: begin
              if (!valid_q || CW'(pos_q) >= count_q) begin
                status_d = STATUS_NONE;
              end else begin
                mark_en = 1'b1;
                if (pos_nxt >= count_q) begin
                  pos_nxt = '0;
                end
                pos_d    = pos_nxt[PW-1:0];
                status_d = STATUS_OK;
                show_d   = 1'b1;
              end
            end
            default: begin
              status_d = STATUS_NONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_fin) begin
          shift_en  = 1'b1;
          count_d   = cnt_m1;
          removed_d = removed_q + CW'(1);
          if (cnt_m1 == '0) begin
            valid_d  = 1'b0;
            pos_d    = '0;
            status_d = STATUS_NONE;
            show_d   = 1'b0;
            state_d  = ST_FIN;
          end else if (CW'(pos_q) >= cnt_m1) begin
            pos_d = '0;
          end
        end else begin
          status_d = STATUS_OK;
          show_d   = 1'b1;
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      valid_q   <= 1'b0;
      removed_q <= '0;
      status_q  <= STATUS_OK;
      show_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      valid_q   <= valid_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      show_q    <= show_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_data_q   <= {6'd0,
                       CountW'(removed_q),
                       CountW'(count_q),
                       valid_q ? IndexW'(pos_q) : IndexW'(0),
                       show_q ? rd_handle : HandleW'(0)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== rtl/rrtt_cell.sv =====
// One table slot: task handle and finished mark, shifts down from its upper neighbor.
module rrtt_cell import rrtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrtt_cell_ctrl_t      ctrl_i,
  input  logic [HandleW-1:0]   new_handle_i,
  input  logic [HandleW-1:0]   nxt_handle_i,
  input  logic                 nxt_fin_i,
  output logic [HandleW-1:0]   handle_o,
  output logic                 fin_o,
  output logic [HandleW-1:0]   rd_handle_o,
  output logic                 rd_fin_o
);

  logic [HandleW-1:0] handle_q;
  logic               fin_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      handle_q <= new_handle_i;
    end else if (ctrl_i.shift) begin
      handle_q <= nxt_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.load) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      fin_q <= nxt_fin_i;
    end else if (ctrl_i.mark) begin
      fin_q <= 1'b1;
    end
  end

  assign handle_o    = handle_q;
  assign fin_o       = fin_q;
  assign rd_handle_o = handle_q & {HandleW{ctrl_i.sel}};
  assign rd_fin_o    = fin_q & ctrl_i.sel;

endmodule

// ===== rtl/rrtt_checker.sv =====
// Port-level checks for the round-robin task table, bound to the top level.
module rrtt_checker import rrtt_pkg::*; #(
  parameter int unsigned MAX_TASKS = 256
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a transaction while busy");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STATUS_FULL |->
      m_axis_tdata[15:0] == '0 && m_axis_tdata[32:24] == CountW'(MAX_TASKS)
      && m_axis_tdata[41:33] == '0)
    else $error("refused add with wrong report");

  a_none_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STATUS_NONE |-> m_axis_tdata[15:0] == '0)
    else $error("handle reported without a current task");

endmodule

bind round_robin_task_table rrtt_checker #(.MAX_TASKS(MAX_TASKS)) u_rrtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/round_robin_task_table_test.sv =====
// Self-checking stream testbench for the round-robin task table.
`timescale 1ns / 100ps

module round_robin_task_table_test;
  import rrtt_pkg::*;

  localparam int unsigned MaxTasks    = 256;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 1000000;

  localparam logic [KindW-1:0] KindSpare = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [5:0]         pad;
    logic [CountW-1:0]  removed;
    logic [CountW-1:0]  live;
    logic [IndexW-1:0]  index;
    logic [HandleW-1:0] handle;
  } table_result_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
    logic               known;
    table_result_t      want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [HandleW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  round_robin_task_table #(
    .MAX_TASKS(MaxTasks)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predicted task table
  logic [HandleW-1:0] tbl_handle [MaxTasks];
  bit                 tbl_done   [MaxTasks];
  int unsigned        tbl_count   = 0;
  int unsigned        tbl_pos     = 0;
  bit                 tbl_current = 1'b0;

  table_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent     = 0;
  int unsigned   cycle_count    = 0;
  bit            sender_calm    = 1'b0;
  bit            hold_output    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic table_result_t next_table_result(input logic [KindW-1:0] kind,
                                                      input logic [HandleW-1:0] handle);
    table_result_t r;
    int unsigned   removed;
    r       = '0;
    removed = 0;
    case (kind)
      KIND_ADD: begin
        if (tbl_count >= MaxTasks) begin
          r.status = STATUS_FULL;
        end else begin
          tbl_handle[tbl_count] = handle;
          tbl_done[tbl_count]   = 1'b0;
          tbl_count++;
          r.status = STATUS_OK;
        end
      end
      KIND_SCHED: begin
        if (tbl_count == 0) begin
          r.status = STATUS_NONE;
        end else begin
          tbl_pos = tbl_current ? tbl_pos + 1 : 0;
          if (tbl_pos >= tbl_count) tbl_pos = 0;
          tbl_current = 1'b1;
          while (tbl_current && tbl_done[tbl_pos]) begin
            for (int unsigned i = tbl_pos; i + 1 < tbl_count; i++) begin
              tbl_handle[i] = tbl_handle[i+1];
              tbl_done[i]   = tbl_done[i+1];
            end
            tbl_count--;
            removed++;
            if (tbl_count == 0) begin
              tbl_current = 1'b0;
              tbl_pos     = 0;
            end else if (tbl_pos >= tbl_count) begin
              tbl_pos = 0;
            end
          end
          if (tbl_current) begin
            r.status = STATUS_OK;
            r.handle = tbl_handle[tbl_pos];
          end else begin
            r.status = STATUS_NONE;
          end
        end
      end
      KIND_EXIT: begin
        if (!tbl_current || tbl_pos >= tbl_count) begin
          r.status = STATUS_NONE;
        end else begin
          tbl_done[tbl_pos] = 1'b1;
          tbl_pos++;
          if (tbl_pos >= tbl_count) tbl_pos = 0;
          r.status = STATUS_OK;
          r.handle = tbl_handle[tbl_pos];
        end
      end
      default: begin
        r.status = STATUS_NONE;
      end
    endcase
    r.index   = tbl_current ? tbl_pos[IndexW-1:0] : '0;
    r.live    = tbl_count[CountW-1:0];
    r.removed = removed[CountW-1:0];
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [KindW-1:0] kind,
                                         input logic [HandleW-1:0] handle, input bit known,
                                         input logic [StatusW-1:0] status,
                                         input logic [HandleW-1:0] chosen,
                                         input int unsigned index, input int unsigned live,
                                         input int unsigned removed);
    stim_row_t row;
    row              = '0;
    row.kind         = kind;
    row.handle       = handle;
    row.known        = known;
    row.want.status  = status;
    row.want.handle  = chosen;
    row.want.index   = index[IndexW-1:0];
    row.want.live    = live[CountW-1:0];
    row.want.removed = removed[CountW-1:0];
    return row;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return HandleW'($urandom);
    endcase
  endfunction

  task automatic offer_request(input logic [KindW-1:0] kind, input logic [HandleW-1:0] handle,
                               input bit known, input table_result_t want);
    int unsigned   gap;
    table_result_t predicted;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= handle;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = next_table_result(kind, handle);
    pending_results.push_back(known ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // append until full, then a few refused adds
  task automatic fill_table();
    int unsigned extra;
    extra = $urandom_range(1, 3);
    while (tbl_count < MaxTasks) offer_request(KIND_ADD, pick_handle(), 1'b0, '0);
    repeat (extra) offer_request(KIND_ADD, pick_handle(), 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // output checker
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.handle !== want.handle) report_mismatch("chosen_handle", want.handle, got.handle);
        if (got.index !== want.index) report_mismatch("chosen_index", want.index, got.index);
        if (got.live !== want.live) report_mismatch("live_count", want.live, got.live);
        if (got.removed !== want.removed)
          report_mismatch("removed_count", want.removed, got.removed);
        if (got.pad !== want.pad) report_mismatch("tdata padding", want.pad, got.pad);
      end
    end
  end

  // receiver: ready bursts with random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        stall = pick_gap();
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned segment;
    int unsigned burst;
    int unsigned pick;
    logic [KindW-1:0] kind;

    // empty table, then three tasks run to completion and get swept out
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 1, STATUS_NONE, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'hFFFF, 1, STATUS_NONE, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KindSpare,  16'hFFFF, 1, STATUS_NONE, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'hFFFF, 1, STATUS_OK,   0, 0, 1, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'h0000, 1, STATUS_OK,   0, 0, 2, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'hA5A5, 1, STATUS_OK,   0, 0, 3, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 1, STATUS_NONE, 0, 0, 3, 0));
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 1, STATUS_OK, 16'hFFFF, 0, 3, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    // wraps onto a finished task
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KindSpare,  16'h0000, 1, STATUS_NONE, 0, 0, 3, 0));
    // every task finished: the tick empties the table
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 1, STATUS_NONE, 0, 0, 0, 3));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 1, STATUS_NONE, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'h1234, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'h5678, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'h9ABC, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_ADD,   16'h0001, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_EXIT,  16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    // wrap plus one deletion
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KindSpare,  16'h8000, 0, STATUS_OK, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(KIND_SCHED, 16'h0000, 0, STATUS_OK, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].kind, directed_rows[i].handle, directed_rows[i].known,
                    directed_rows[i].want);

    // long output stall while the table fills, then a full pause
    hold_output = 1'b1;
    fill_table();
    wait_for_results();

    while (items_sent < directed_rows.size() + RandomItems) begin
      segment     = $urandom_range(0, 11);
      sender_calm = ($urandom_range(0, 4) == 0);
      if (segment == 0) begin
        fill_table();
      end else if (segment <= 3) begin
        // finish all or part of the table, then sweep it
        burst = ($urandom_range(0, 1) == 0) ? tbl_count + $urandom_range(0, 3)
                                            : $urandom_range(0, tbl_count);
        repeat (burst) offer_request(KIND_EXIT, pick_handle(), 1'b0, '0);
        repeat ($urandom_range(1, 3)) offer_request(KIND_SCHED, pick_handle(), 1'b0, '0);
      end else begin
        burst = $urandom_range(10, 40);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 38)      kind = KIND_ADD;
          else if (pick < 68) kind = KIND_SCHED;
          else if (pick < 95) kind = KIND_EXIT;
          else                kind = KindSpare;
          offer_request(kind, pick_handle(), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
